/* rtl/csvp_pkg.sv */
package csvp_pkg;

   // Character codes that steer the parser.
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // Result kinds.
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Saturation limits, clamp bounds and the reset value of the offset.
   localparam logic [23:0] ROW_MAX     = 24'hFF_FFFF;
   localparam logic [15:0] COL_MAX     = 16'hFFFF;
   localparam logic [31:0] POS_LIMIT   = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT   = 32'h8000_0000;
   localparam logic [31:0] OFFSET_INIT = 32'hFFFF_D8F0;

   // Parser phase within one field.
   typedef enum logic [1:0] {
      PHASE_BLANK  = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   // Finished field handed from the scanner to the statistics stage.
   typedef struct packed {
      logic        kind;
      logic [31:0] magnitude;
      logic        negative;
      logic [23:0] rows;
      logic [15:0] columns;
   } field_type;

endpackage

/* rtl/csv_integer_field_parser.sv */
// Channel  Direction  tdata / data                               tuser
// req      in         [7:0] text_byte                            end_of_input
// rsp      out        [15:0] sample, [47:16] least_seen,         item_kind
//                     [79:48] greatest_seen, [103:80] rows_seen,
//                     [119:104] columns_last_row
// csr      in         [31:0] value_offset                        -
//
// One byte is accepted every cycle while the stage register is empty or moving on; a
// byte that finishes a field has its result registered in the stage register first.
// The field scanner registers each finished field; the statistics stage applies the
// offset and min/max update and loads the output register.
// Reset is synchronous and active high; it restores value_offset to -10000.
// A stalled result beat holds the output register; bytes that finish no field keep
// flowing, and the first one that finishes a field waits in the stage register.
module csv_integer_field_parser
   import csvp_pkg::*;
#(
   parameter int FIELD_CHAR_LIMIT = 50
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] text_byte
   input  logic         req_tuser,   // [0] end_of_input
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // sample, least_seen, greatest_seen, rows_seen,
                                     // columns_last_row
   output logic         rsp_tuser,   // [0] item_kind
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data     // [31:0] value_offset
);

   logic [31:0] value_offset_ff, value_offset_in;
   logic        req_fire;
   logic        s1_valid;
   logic        s1_ready;
   field_type   s1_field;

   // Offset register.
   assign csr_ready       = 1'b1;
   assign value_offset_in = (csr_valid && csr_ready) ? csr_data : value_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_offset_ff <= OFFSET_INIT;
      end else begin
         value_offset_ff <= value_offset_in;
      end
   end

   // A byte enters when the stage register is empty or about to move on.
   assign req_tready = !s1_valid || s1_ready;
   assign req_fire   = req_tvalid && req_tready;

   csvp_scan #(
      .FIELD_CHAR_LIMIT (FIELD_CHAR_LIMIT)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .text_byte    (req_tdata),
      .end_of_input (req_tuser),
      .s1_ready     (s1_ready),
      .s1_valid     (s1_valid),
      .s1_field     (s1_field)
   );

   csvp_stats u_stats (
      .clock        (clock),
      .reset        (reset),
      .value_offset (value_offset_ff),
      .s1_valid     (s1_valid),
      .s1_field     (s1_field),
      .s1_ready     (s1_ready),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_kind     (rsp_tuser),
      .rsp_data     (rsp_tdata)
   );

endmodule

/* rtl/csvp_scan.sv */
module csvp_scan
   import csvp_pkg::*;
#(
   parameter int FIELD_CHAR_LIMIT = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  logic [7:0]  text_byte,
   input  logic        end_of_input,
   input  logic        s1_ready,
   output logic        s1_valid,
   output field_type   s1_field
);

   localparam logic [7:0] LIMIT = 8'(FIELD_CHAR_LIMIT);

   logic [31:0] field_magnitude_ff, field_magnitude_in;
   logic        field_negative_ff, field_negative_in;
   phase_type   parse_phase_ff, parse_phase_in;
   logic [7:0]  field_char_count_ff, field_char_count_in;
   logic [23:0] row_count_ff, row_count_in;
   logic [15:0] column_count_ff, column_count_in;
   logic [15:0] last_row_columns_ff, last_row_columns_in;
   logic        s1_valid_ff, s1_valid_in;
   field_type   s1_field_ff, s1_field_in;

   logic [35:0] times_ten;
   logic [31:0] digit_magnitude;
   logic [31:0] parsed_magnitude;
   logic        parsed_negative;
   phase_type   parsed_phase;
   logic [7:0]  count_next;
   logic [15:0] column_inc;
   logic [23:0] row_inc;
   logic        is_digit;
   logic        is_blank;
   logic        emit;
   logic        emit_kind;

   // Magnitude times ten plus the digit, saturating at 32 bits.
   assign times_ten = ({4'd0, field_magnitude_ff} << 3) + ({4'd0, field_magnitude_ff} << 1)
                      + {32'd0, text_byte[3:0]};
   assign digit_magnitude = (times_ten[35:32] != 4'd0) ? '1 : times_ten[31:0];

   assign count_next = field_char_count_ff + 8'd1;
   assign column_inc = (column_count_ff == COL_MAX) ? column_count_ff : column_count_ff + 16'd1;
   assign row_inc    = (row_count_ff == ROW_MAX) ? row_count_ff : row_count_ff + 24'd1;

   assign is_digit = text_byte inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_blank = text_byte inside {CHAR_SPACE, CHAR_TAB, CHAR_VTAB, CHAR_FF, CHAR_CR};

   // Effect of one ordinary character on the field being parsed.
   always_comb begin
      parsed_magnitude = field_magnitude_ff;
      parsed_negative  = field_negative_ff;
      parsed_phase     = parse_phase_ff;
      case (parse_phase_ff)
         PHASE_BLANK: begin
            if (is_blank) begin
               parsed_phase = PHASE_BLANK;
            end else if (text_byte == CHAR_PLUS || text_byte == CHAR_MINUS) begin
               parsed_negative = (text_byte == CHAR_MINUS);
               parsed_phase    = PHASE_DIGITS;
            end else if (is_digit) begin
               parsed_magnitude = digit_magnitude;
               parsed_phase     = PHASE_DIGITS;
            end else begin
               parsed_phase = PHASE_DONE;
            end
         end
         PHASE_DIGITS: begin
            if (is_digit) begin
               parsed_magnitude = digit_magnitude;
            end else begin
               parsed_phase = PHASE_DONE;
            end
         end
         default: begin
            parsed_phase = PHASE_DONE;
         end
      endcase
   end

   // Field, row and column bookkeeping for an accepted beat.
   always_comb begin
      field_magnitude_in  = field_magnitude_ff;
      field_negative_in   = field_negative_ff;
      parse_phase_in      = parse_phase_ff;
      field_char_count_in = field_char_count_ff;
      row_count_in        = row_count_ff;
      column_count_in     = column_count_ff;
      last_row_columns_in = last_row_columns_ff;
      emit                = 1'b0;
      emit_kind           = KIND_SAMPLE;
      s1_field_in.magnitude = field_magnitude_ff;
      s1_field_in.negative  = field_negative_ff;
      if (req_fire) begin
         if (end_of_input) begin
            emit      = 1'b1;
            emit_kind = KIND_SUMMARY;
            column_count_in = 16'd0;
         end else if (text_byte == CHAR_COMMA) begin
            emit = 1'b1;
            column_count_in = column_inc;
         end else if (text_byte == CHAR_NEWLINE) begin
            emit = 1'b1;
            column_count_in     = 16'd0;
            last_row_columns_in = column_inc;
            row_count_in        = row_inc;
         end else if (count_next >= LIMIT) begin
            emit = 1'b1;
            column_count_in = column_inc;
            s1_field_in.magnitude = parsed_magnitude;
            s1_field_in.negative  = parsed_negative;
         end else begin
            field_magnitude_in  = parsed_magnitude;
            field_negative_in   = parsed_negative;
            parse_phase_in      = parsed_phase;
            field_char_count_in = count_next;
         end
         // Any emitted item starts a fresh field.
         if (emit) begin
            field_magnitude_in  = 32'd0;
            field_negative_in   = 1'b0;
            parse_phase_in      = PHASE_BLANK;
            field_char_count_in = 8'd0;
         end
      end
      s1_field_in.kind    = emit_kind;
      s1_field_in.rows    = row_count_in;
      s1_field_in.columns = last_row_columns_in;
   end

   // Stage register hand-off: a held item leaves when the next stage takes it.
   always_comb begin
      if (req_fire) begin
         s1_valid_in = emit;
      end else if (s1_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_magnitude_ff  <= 32'd0;
         field_negative_ff   <= 1'b0;
         parse_phase_ff      <= PHASE_BLANK;
         field_char_count_ff <= 8'd0;
         row_count_ff        <= 24'd0;
         column_count_ff     <= 16'd0;
         last_row_columns_ff <= 16'd0;
         s1_valid_ff         <= 1'b0;
      end else begin
         field_magnitude_ff  <= field_magnitude_in;
         field_negative_ff   <= field_negative_in;
         parse_phase_ff      <= parse_phase_in;
         field_char_count_ff <= field_char_count_in;
         row_count_ff        <= row_count_in;
         column_count_ff     <= column_count_in;
         last_row_columns_ff <= last_row_columns_in;
         s1_valid_ff         <= s1_valid_in;
      end
   end

   // Payload of the stage register.
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         s1_field_ff <= s1_field_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_field = s1_field_ff;

`ifndef NO_ASSERTIONS
   // A field never rests at the character limit; reaching it flushes the field.
   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      field_char_count_ff < LIMIT)
      else $error("field character count reached the limit");

   // While still skipping blanks, no sign or digit has been taken.
   a_blank_phase_clean: assert property (@(posedge clock) disable iff (reset)
      (parse_phase_ff == PHASE_BLANK) |-> (field_magnitude_ff == 32'd0 && !field_negative_ff))
      else $error("field state not clean in blank phase");

   // End of input drops the partial field and the partial row.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && end_of_input) |=>
         (column_count_ff == 16'd0 && parse_phase_ff == PHASE_BLANK))
      else $error("end of input did not clear the field");
`endif

endmodule

/* rtl/csvp_stats.sv */
module csvp_stats
   import csvp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [31:0]  value_offset,
   input  logic         s1_valid,
   input  field_type    s1_field,
   output logic         s1_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_kind,
   output logic [119:0] rsp_data
);

   logic [31:0]  running_min_ff, running_min_in;
   logic [31:0]  running_max_ff, running_max_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_kind_ff;
   logic [119:0] rsp_data_ff, rsp_data_in;

   logic [31:0] clamped;
   logic [31:0] offset_value;
   logic        take;

   assign s1_ready = !rsp_valid_ff || rsp_ready;
   assign take     = s1_valid && s1_ready;

   // Clamp the magnitude into the signed 32-bit range and apply the offset.
   always_comb begin
      if (s1_field.negative) begin
         clamped = 32'd0 - ((s1_field.magnitude > NEG_LIMIT) ? NEG_LIMIT : s1_field.magnitude);
      end else begin
         clamped = (s1_field.magnitude > POS_LIMIT) ? POS_LIMIT : s1_field.magnitude;
      end
      offset_value = clamped - value_offset;
   end

   // Extrema update and result assembly.
   always_comb begin
      running_min_in = running_min_ff;
      running_max_in = running_max_ff;
      if (take && s1_field.kind == KIND_SAMPLE) begin
         if ($signed(offset_value) < $signed(running_min_ff)) begin
            running_min_in = offset_value;
         end
         if ($signed(offset_value) > $signed(running_max_ff)) begin
            running_max_in = offset_value;
         end
      end
      rsp_data_in = {s1_field.columns, s1_field.rows, running_max_in, running_min_in,
                     (s1_field.kind == KIND_SAMPLE) ? offset_value[15:0] : 16'd0};
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_min_ff <= 32'd0;
         running_max_ff <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_min_ff <= running_min_in;
         running_max_ff <= running_max_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_kind_ff <= s1_field.kind;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // Both extrema start at zero, so the minimum never rises above it nor the maximum below.
   a_extrema_order: assert property (@(posedge clock) disable iff (reset)
      ($signed(running_min_ff) <= 0 && $signed(running_max_ff) >= 0))
      else $error("running extrema out of order");

   // A summary leaves the extrema untouched.
   a_summary_keeps_extrema: assert property (@(posedge clock) disable iff (reset)
      (take && s1_field.kind == KIND_SUMMARY) |=>
         ($stable(running_min_ff) && $stable(running_max_ff)))
      else $error("summary changed the extrema");
`endif

endmodule

/* sim/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import csvp_pkg::*;

   localparam int CHAR_LIMIT     = 50;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_BYTES    = 241;
   localparam int DIR_ROWS       = 27;

   localparam logic [7:0] BLANK_CHARS [5] = '{CHAR_SPACE, CHAR_TAB, CHAR_VTAB, CHAR_FF, CHAR_CR};

   // One result beat: the item kind, then the tdata fields from sample up to columns_last_row.
   typedef struct packed {
      logic        kind;
      logic [15:0] sample;
      logic [31:0] least;
      logic [31:0] greatest;
      logic [23:0] rows;
      logic [15:0] columns;
   } csv_result_type;

   // One row of the directed text: a byte, its end-of-input flag, how often it repeats,
   // and an optional hand-written result that replaces the computed one.
   typedef struct {
      logic [7:0]     text;
      logic           eoi;
      int             reps;
      bit             typed;
      csv_result_type want;
   } text_row_type;

   typedef struct packed {
      logic [7:0] text;
      logic       eoi;
   } text_beat_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_data   = '0;

   // Parser state as the testbench sees it.
   logic [31:0]        offset_now;
   logic [31:0]        fld_mag;
   logic               fld_neg;
   phase_type          fld_phase;
   logic [7:0]         fld_chars;
   logic signed [31:0] low_mark;
   logic signed [31:0] high_mark;
   logic [23:0]        row_total;
   logic [15:0]        col_run;
   logic [15:0]        col_last;

   csv_result_type pending_results [$];
   text_beat_type  text_pending [$];
   text_row_type   dir_rows [DIR_ROWS];
   int unsigned err_count   = 0;
   int unsigned gap_pct     = 0;
   int unsigned stall_pct   = 0;
   int unsigned quiet_cycles = 0;
   bit          override_on = 1'b0;
   csv_result_type override_item;

   csv_integer_field_parser #(
      .FIELD_CHAR_LIMIT(CHAR_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_field_state();
      fld_mag   = '0;
      fld_neg   = 1'b0;
      fld_phase = PHASE_BLANK;
      fld_chars = '0;
   endfunction

   function automatic void reset_parser_state();
      offset_now = OFFSET_INIT;
      clear_field_state();
      low_mark  = '0;
      high_mark = '0;
      row_total = '0;
      col_run   = '0;
      col_last  = '0;
   endfunction

   // Accumulate one decimal digit, saturating the magnitude at 32 bits.
   function automatic void add_digit(input logic [7:0] ch);
      logic [63:0] prod;
      prod    = {32'd0, fld_mag} * 64'd10 + {56'd0, ch - CHAR_ZERO};
      fld_mag = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
   endfunction

   // Clamp the signed value, apply the offset, update extremes and the column count.
   function automatic logic [31:0] close_field();
      logic [31:0]        mag_clamped;
      logic signed [31:0] val;
      if (fld_neg) begin
         mag_clamped = (fld_mag > NEG_LIMIT) ? NEG_LIMIT : fld_mag;
         val = -mag_clamped;
      end else begin
         val = (fld_mag > POS_LIMIT) ? POS_LIMIT : fld_mag;
      end
      val = val - offset_now;
      if (val < low_mark) low_mark = val;
      if (val > high_mark) high_mark = val;
      if (col_run != COL_MAX) col_run = col_run + 16'd1;
      clear_field_state();
      return val;
   endfunction

   // Advance the parser by one beat; returns 1 when the beat yields a result.
   function automatic bit parse_text_byte(input logic [7:0] ch, input logic eoi,
                                          output csv_result_type res);
      bit          has_result;
      bit          is_digit;
      bit          is_blank;
      logic [31:0] val;
      has_result = 1'b0;
      val        = '0;
      is_digit   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      is_blank   = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_VTAB) ||
                   (ch == CHAR_FF) || (ch == CHAR_CR);
      if (eoi) begin
         // End of text drops the open field and the partial row.
         clear_field_state();
         col_run    = '0;
         has_result = 1'b1;
      end else if (ch == CHAR_COMMA || ch == CHAR_NEWLINE) begin
         val = close_field();
         if (ch == CHAR_NEWLINE) begin
            if (row_total != ROW_MAX) row_total = row_total + 24'd1;
            col_last = col_run;
            col_run  = '0;
         end
         has_result = 1'b1;
      end else begin
         case (fld_phase)
            PHASE_BLANK: begin
               if (!is_blank) begin
                  if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
                     fld_neg   = (ch == CHAR_MINUS);
                     fld_phase = PHASE_DIGITS;
                  end else if (is_digit) begin
                     add_digit(ch);
                     fld_phase = PHASE_DIGITS;
                  end else begin
                     fld_phase = PHASE_DONE;
                  end
               end
            end
            PHASE_DIGITS: begin
               if (is_digit) add_digit(ch);
               else fld_phase = PHASE_DONE;
            end
            default: ;
         endcase
         // The byte that fills the field to its limit closes it.
         fld_chars = fld_chars + 8'd1;
         if (fld_chars >= CHAR_LIMIT) begin
            val        = close_field();
            has_result = 1'b1;
         end
      end
      res.kind     = eoi ? KIND_SUMMARY : KIND_SAMPLE;
      res.sample   = val[15:0];
      res.least    = low_mark;
      res.greatest = high_mark;
      res.rows     = row_total;
      res.columns  = col_last;
      return has_result;
   endfunction

   // Check result beats against the oldest expectation, then predict from input beats.
   always @(posedge clock) begin
      csv_result_type got;
      csv_result_type want;
      csv_result_type predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16], rsp_tdata[79:48],
                   rsp_tdata[103:80], rsp_tdata[119:104]};
            if (pending_results.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display("%0t: result beat with nothing expected: kind %0d sample %h",
                           $time, got.kind, got.sample);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  err_count++;
                  if (err_count <= MAX_REPORTS) begin
                     $display("%0t: result mismatch (expected / actual)", $time);
                     $display("   kind %0d / %0d, sample %h / %h", want.kind, got.kind,
                              want.sample, got.sample);
                     $display("   least %0d / %0d, greatest %0d / %0d",
                              $signed(want.least), $signed(got.least),
                              $signed(want.greatest), $signed(got.greatest));
                     $display("   rows %0d / %0d, columns %0d / %0d", want.rows, got.rows,
                              want.columns, got.columns);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (parse_text_byte(req_tdata, req_tuser, predicted))
               pending_results.push_back(override_on ? override_item : predicted);
         end
         if (csr_valid && csr_ready) offset_now = csr_data;
      end
   end

   // Watchdog: end the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Drive one text beat, with random gaps in front, and wait for it to be taken.
   task automatic send_beat(input logic [7:0] ch, input logic eoi, input bit typed,
                            input csv_result_type want);
      override_on   = typed;
      override_item = want;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= eoi;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
      override_on = 1'b0;
   endtask

   // Stop sending and wait until every expected result beat has arrived.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_offset(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void push_text(input logic [7:0] ch);
      text_pending.push_back('{ch, 1'b0});
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   // Queue one random record: mostly well-formed fields, some noise, long fields
   // that run into the character limit, and end-of-text beats.
   function automatic void queue_record();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 5) begin
         text_pending.push_back('{8'($urandom_range(255)), 1'b1});
      end else if (pick < 13) begin
         repeat ($urandom_range(4, 1)) push_text(8'($urandom_range(255)));
      end else if (pick < 17) begin
         n = $urandom_range(60, 45);
         repeat (n) begin
            case ($urandom_range(2))
               0: push_text(random_digit());
               1: push_text(CHAR_SPACE);
               default: push_text(8'($urandom_range(255)));
            endcase
         end
      end else begin
         repeat ($urandom_range(2)) push_text(BLANK_CHARS[$urandom_range(4)]);
         if ($urandom_range(9) < 3) push_text($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
         n = ($urandom_range(9) < 2) ? $urandom_range(12, 8) : $urandom_range(5, 0);
         repeat (n) push_text(random_digit());
         // Occasional junk after the number, which must be ignored.
         if ($urandom_range(9) == 0) begin
            push_text(8'h61 + 8'($urandom_range(25)));
            push_text(random_digit());
         end
         push_text(($urandom_range(3) == 0) ? CHAR_NEWLINE : CHAR_COMMA);
      end
   endfunction

   task automatic run_random(input int unsigned count, input bit pause_mid);
      text_beat_type beat;
      int unsigned   sent;
      sent = 0;
      while (sent < count) begin
         if (text_pending.size() == 0) queue_record();
         beat = text_pending.pop_front();
         send_beat(beat.text, beat.eoi, 1'b0, '0);
         sent++;
         if (pause_mid && sent == count / 2) wait_idle();
      end
      text_pending.delete();
   endtask

   initial begin
      logic [31:0] phase_offset [5];
      int unsigned phase_gap [5];
      int unsigned phase_stall [5];

      // Directed text: whitespace kinds, signs, saturation both ways, junk after
      // digits, empty fields, the character limit, odd bytes, end of text.
      dir_rows = '{
         '{8'h00,        1'b1, 1,  1'b1, '{KIND_SUMMARY, 16'h0000, 32'd0, 32'd0, 24'd0, 16'd0}},
         '{CHAR_COMMA,   1'b0, 1,  1'b1, '{KIND_SAMPLE, 16'h2710, 32'd0, 32'd10000, 24'd0,
                                           16'd0}},
         '{CHAR_SPACE,   1'b0, 1,  1'b0, '0},
         '{CHAR_TAB,     1'b0, 1,  1'b0, '0},
         '{CHAR_VTAB,    1'b0, 1,  1'b0, '0},
         '{CHAR_FF,      1'b0, 1,  1'b0, '0},
         '{CHAR_CR,      1'b0, 1,  1'b0, '0},
         '{CHAR_MINUS,   1'b0, 1,  1'b0, '0},
         '{CHAR_NINE,    1'b0, 10, 1'b0, '0},
         '{CHAR_NEWLINE, 1'b0, 1,  1'b0, '0},
         '{CHAR_PLUS,    1'b0, 1,  1'b0, '0},
         '{CHAR_NINE,    1'b0, 12, 1'b0, '0},
         '{CHAR_COMMA,   1'b0, 1,  1'b0, '0},
         '{8'h78,        1'b0, 1,  1'b0, '0},
         '{8'h37,        1'b0, 1,  1'b0, '0},
         '{CHAR_COMMA,   1'b0, 1,  1'b0, '0},
         '{8'h31,        1'b0, 1,  1'b0, '0},
         '{8'h61,        1'b0, 1,  1'b0, '0},
         '{8'h33,        1'b0, 1,  1'b0, '0},
         '{CHAR_COMMA,   1'b0, 1,  1'b0, '0},
         '{CHAR_SPACE,   1'b0, 50, 1'b0, '0},
         '{8'h35,        1'b0, 50, 1'b0, '0},
         '{8'h00,        1'b0, 1,  1'b0, '0},
         '{8'hFF,        1'b0, 1,  1'b0, '0},
         '{CHAR_NEWLINE, 1'b0, 1,  1'b0, '0},
         '{CHAR_ZERO,    1'b0, 1,  1'b0, '0},
         '{8'hA5,        1'b1, 1,  1'b0, '0}
      };

      // Offset extremes and zero first, then random ones; each phase has its own idling mix.
      phase_offset = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, $urandom, $urandom};
      phase_gap    = '{0, 70, 0, 17, 17};
      phase_stall  = '{0, 0, 70, 17, 0};

      reset_parser_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         for (int r = 0; r < dir_rows[i].reps; r++)
            send_beat(dir_rows[i].text, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].want);
      end
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         gap_pct   = phase_gap[p];
         stall_pct = phase_stall[p];
         write_offset(phase_offset[p]);
         run_random(PHASE_BYTES, p == 2);
         wait_idle();
      end

      if (pending_results.size() != 0) begin
         err_count += pending_results.size();
         $display("%0d expected result beats never arrived", pending_results.size());
      end
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
